// ===== design/lis_pkg.sv =====
// shared constants and handshake structs for the longest increasing subsequence block
// no dependencies; imported by every module in the design folder

package lis_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int VALUE_WIDTH = 32;

    // tails store address and length counter widths
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);

    // fixed widths of the stream fields
    localparam int IN_VALUE_W = 32;
    localparam int OUT_LEN_W  = 11;
    localparam int OUT_DATA_W = 16;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    // request from the item control to the search sequencer
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] len;
    } lis_srch_cmd_t;

    // status from the search sequencer
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [LEN_W-1:0] pos;
    } lis_srch_stat_t;

endpackage

// ===== design/longest_increasing_subsequence.sv =====
// top level of the longest increasing subsequence block: stream ports, length and flag
// depends on lis_pkg, lis_tails_ram and lis_search
//
//  channel   dir   tdata (low bit up)                     tuser
//  s_axis    in    [31:0] value (signed)                  [0] start_new
//  m_axis    out   [10:0] lis_length, [11] overflow,      none
//                  [15:12] zero
//
// each beat runs a binary search over the tails below len, the filled tail count;
// the search makes one probe per cycle through the tails ram read port, and the
// next beat is not taken until the search is done
// reset clears length, overflow flag and the output valid flag; the tails ram
// is not cleared, since only entries below the length are ever read
// a result waits in the output register; the next beat is taken while it drains

module longest_increasing_subsequence (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lis_pkg::IN_VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic                            s_axis_tuser,   // [0] start_new
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lis_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // [10:0] lis_length, [11] overflow
);
    import lis_pkg::*;

    logic                   in_fire;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_LEN_W:0]     out_data_reg;

    lis_srch_cmd_t          srch_cmd;
    lis_srch_stat_t         srch_stat;

    logic [ADDR_W-1:0]      rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic                   is_append;

    // take a beat only out of reset, with the search idle and the output slot free or draining
    assign s_axis_tready = rst_n && !srch_stat.busy && (!out_valid_reg || m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // start_new restarts the length before the search window is set
    assign srch_cmd = '{start: in_fire, len: (s_axis_tuser ? '0 : len_reg)};

    // search ended at the fill count: the beat extends the run
    assign is_append = (srch_stat.pos == len_reg);
    assign wr_en     = srch_stat.done && (!is_append || (len_reg != LEN_MAX));

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (in_fire && s_axis_tuser)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (srch_stat.done && is_append)
        begin
            if (len_reg != LEN_MAX)
            begin
                len_next = len_reg + LEN_W'(1);
            end
            else
            begin
                // store full, append dropped
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (srch_stat.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            // narrow or sign-extend the input value to the tail width
            key_reg <= VALUE_WIDTH'($signed(s_axis_tdata));
        end
        if (srch_stat.done)
        begin
            out_data_reg <= {ovf_next, OUT_LEN_W'(len_next)};
        end
    end

    lis_search u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (srch_cmd),
        .key     (key_reg),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .stat    (srch_stat)
    );

    // replace at the found slot, or append at the fill count
    lis_tails_ram u_tails (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (srch_stat.pos[ADDR_W-1:0]),
        .wr_data (key_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_LEN_W - 1)'(0), out_data_reg};

endmodule

// ===== design/lis_tails_ram.sv =====
// tails store: one write port, one registered read port
// depends on lis_pkg for depth and value width

module lis_tails_ram (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [lis_pkg::ADDR_W-1:0]       wr_addr,
    input  logic [lis_pkg::VALUE_WIDTH-1:0]  wr_data,
    input  logic [lis_pkg::ADDR_W-1:0]       rd_addr,
    output logic [lis_pkg::VALUE_WIDTH-1:0]  rd_data
);
    import lis_pkg::*;

    logic [VALUE_WIDTH-1:0] tails_mem [MAX_LEN];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tails_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= tails_mem[rd_addr];
    end

endmodule

// ===== design/lis_search.sv =====
// binary search sequencer: one shared signed compare, one probe per cycle
// depends on lis_pkg; drives the read address of lis_tails_ram

module lis_search (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lis_pkg::lis_srch_cmd_t           cmd,
    input  logic [lis_pkg::VALUE_WIDTH-1:0]  key,
    input  logic [lis_pkg::VALUE_WIDTH-1:0]  rd_data,
    output logic [lis_pkg::ADDR_W-1:0]       rd_addr,
    output lis_pkg::lis_srch_stat_t          stat
);
    import lis_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic             state_reg, state_next;
    logic [LEN_W-1:0] lo_reg, lo_next;
    logic [LEN_W-1:0] hi_reg, hi_next;
    logic [LEN_W-1:0] mid_cur;
    logic [LEN_W-1:0] mid_next;
    logic             tail_ge;
    logic             search_done;

    // probe point of the current window; its tail sits on rd_data now
    assign mid_cur  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign mid_next = lo_next + ((hi_next - lo_next) >> 1);
    assign tail_ge  = $signed(rd_data) >= $signed(key);

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        search_done = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    lo_next    = '0;
                    hi_next    = cmd.len;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg == hi_reg)
                begin
                    search_done = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (tail_ge)
                begin
                    hi_next = mid_cur;
                end
                else
                begin
                    lo_next = mid_cur + LEN_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // mid never reaches MAX_LEN while the window is open
    assign rd_addr = mid_next[ADDR_W-1:0];
    assign stat    = '{busy: (state_reg == S_SEARCH), done: search_done, pos: lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule
